FILE: hw/rtl/ppg_pkg.sv
// ----------------------------------------------------------------------------
// Plasma pixel generator package
// Shared widths, fixed-point constants and register indexes.
// ----------------------------------------------------------------------------
package ppg_pkg;

   // Field widths.
   localparam int COORD_W  = 10;
   localparam int GRAY_W   = 8;
   localparam int OFFS_W   = 22;
   localparam int PHASE_W  = 16;
   localparam int STRIDE_W = 13;
   localparam int ANGLE_W  = 32;
   localparam int TERM_W   = 16;

   // Stream and register port widths.
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Coordinates at or above this limit are saturated.
   localparam int MAX_DIM = 1024;

   // Default depth of the quarter-wave sine table.
   localparam int SINE_DEPTH_DEF = 1024;

   // Radicand (x*x + y*y) << 8 and its integer root with 4 fraction bits.
   localparam int RAD_W  = 30;
   localparam int ROOT_W = RAD_W / 2;

   // Turn-angle scale factors in Q0.32 per unit of coordinate.
   localparam logic [ANGLE_W-1:0] K_X7  = 32'd97652182;
   localparam logic [ANGLE_W-1:0] K_Y5  = 32'd136713055;
   localparam logic [ANGLE_W-1:0] K_XY6 = 32'd113927546;
   localparam logic [ANGLE_W-1:0] K_R4  = 32'd10680707;

   // Sine amplitude and term scale (127 in Q8.8).
   localparam logic [63:0] SINE_AMP   = 64'd2047;
   localparam logic [63:0] TERM_SCALE = 64'd32512;

   // Register reset values.
   localparam logic [PHASE_W-1:0]  PHASE_RESET  = '0;
   localparam logic [STRIDE_W-1:0] STRIDE_RESET = 13'd4096;

   // Register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PHASE  = 2'd0,
      CSR_STRIDE = 2'd1
   } csr_index_type;

endpackage

FILE: hw/rtl/ppg_sine_rom.sv
// ----------------------------------------------------------------------------
// Plasma sine term ROM
// Quarter-wave table holding, per entry, the Q8.8 plasma term for the
// positive and the negative half wave. Registered read.
// ----------------------------------------------------------------------------
module ppg_sine_rom #(
   parameter int DEPTH = ppg_pkg::SINE_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic [$clog2(DEPTH):0]        addr,
   output logic [2*ppg_pkg::TERM_W-1:0]  data
);

   localparam int ENTRY_W = 2 * ppg_pkg::TERM_W;

   typedef logic [ENTRY_W-1:0] rom_type [DEPTH+1];

   // Horner-form Taylor sine in Q30, scaled to the amplitude, then mapped
   // to the plasma term for both signs.
   function automatic rom_type build_rom();
      rom_type     tab;
      logic [63:0] u;
      logic [63:0] u2;
      logic [63:0] p;
      logic [63:0] v;
      logic [63:0] tp;
      logic [63:0] tn;
      for (int i = 0; i <= DEPTH; i++) begin
         u  = (64'(i) << 30) / DEPTH;
         u2 = (u * u) >> 30;
         p  = 64'd172272;
         p  = 64'd5026995    - ((u2 * p) >> 30);
         p  = 64'd85569306   - ((u2 * p) >> 30);
         p  = 64'd693598670  - ((u2 * p) >> 30);
         p  = 64'd1686629713 - ((u2 * p) >> 30);
         p  = (u * p) >> 30;
         v  = (p * ppg_pkg::SINE_AMP + (64'd1 << 29)) >> 30;
         if (v > ppg_pkg::SINE_AMP) begin
            v = ppg_pkg::SINE_AMP;
         end
         tp = (ppg_pkg::TERM_SCALE * (ppg_pkg::SINE_AMP + v)) / ppg_pkg::SINE_AMP;
         tn = (ppg_pkg::TERM_SCALE * (ppg_pkg::SINE_AMP - v)) / ppg_pkg::SINE_AMP;
         tab[i] = {tn[ppg_pkg::TERM_W-1:0], tp[ppg_pkg::TERM_W-1:0]};
      end
      return tab;
   endfunction

   localparam rom_type ROM = build_rom();

   logic [ENTRY_W-1:0] data_ff;

   // Registered read.
   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= ROM[addr];
      end
   end

   assign data = data_ff;

endmodule

FILE: hw/rtl/ppg_sqrt_pipe.sv
// ----------------------------------------------------------------------------
// Plasma square root pipeline
// Digit-by-digit integer square root, one root bit per stage, with a
// sideband word carried alongside.
// ----------------------------------------------------------------------------
module ppg_sqrt_pipe #(
   parameter int RAD_W  = ppg_pkg::RAD_W,
   parameter int SIDE_W = 42
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [RAD_W-1:0]     in_rad,
   input  logic [SIDE_W-1:0]    in_side,
   output logic                 out_valid,
   output logic [RAD_W/2-1:0]   out_root,
   output logic [SIDE_W-1:0]    out_side
);

   localparam int QW    = RAD_W / 2;
   localparam int REM_W = QW + 2;

   logic              vld_ff  [QW];
   logic [RAD_W-1:0]  rad_ff  [QW];
   logic [REM_W-1:0]  rem_ff  [QW];
   logic [QW-1:0]     root_ff [QW];
   logic [SIDE_W-1:0] side_ff [QW];

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic              vld_src;
      logic [RAD_W-1:0]  rad_src;
      logic [REM_W-1:0]  rem_src;
      logic [QW-1:0]     root_src;
      logic [SIDE_W-1:0] side_src;
      logic [REM_W-1:0]  shifted;
      logic [REM_W-1:0]  trial;
      logic [REM_W-1:0]  rem_in;
      logic [QW-1:0]     root_in;

      // Stage source: pipeline input or the previous stage.
      if (k == 0) begin : g_first
         assign vld_src  = in_valid;
         assign rad_src  = in_rad;
         assign rem_src  = '0;
         assign root_src = '0;
         assign side_src = in_side;
      end else begin : g_next
         assign vld_src  = vld_ff[k-1];
         assign rad_src  = rad_ff[k-1];
         assign rem_src  = rem_ff[k-1];
         assign root_src = root_ff[k-1];
         assign side_src = side_ff[k-1];
      end

      // Bring down two radicand bits and try the next root bit.
      always_comb begin
         shifted = {rem_src[REM_W-3:0], rad_src[RAD_W-1-2*k -: 2]};
         trial   = {root_src, 2'b01};
         if (shifted >= trial) begin
            rem_in  = shifted - trial;
            root_in = {root_src[QW-2:0], 1'b1};
         end else begin
            rem_in  = shifted;
            root_in = {root_src[QW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[k]  <= rad_src;
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            side_ff[k] <= side_src;
         end
      end
   end

   assign out_valid = vld_ff[QW-1];
   assign out_root  = root_ff[QW-1];
   assign out_side  = side_ff[QW-1];

endmodule

FILE: hw/rtl/plasma_pixel_generator_unit.sv
// ----------------------------------------------------------------------------
// Plasma pixel generator
// Gives the plasma gray level and the RGBA byte offset of each pixel.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                Payload
//  req_      in         req_tvalid/req_tready    pos_x, pos_y
//  rsp_      out        rsp_tvalid/rsp_tready    gray_level, byte_offset
//  csr_      in         csr_valid/csr_ready      csr_index, csr_data
//
// One request per clock while the output is not stalled; each request passes
// 20 register stages on its way to the result.
// Most of them are the square root pipeline, one root bit per stage.
// Reset clears the valid bits and loads phase 0 and row stride 4096.
// A stalled result holds the whole pipeline; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module plasma_pixel_generator_unit #(
   parameter int SINE_TABLE_DEPTH = ppg_pkg::SINE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // [9:0] pos_x, [19:10] pos_y
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [ppg_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [7:0] gray_level, [29:8] byte_offset
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ppg_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ppg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ppg_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int CW     = ppg_pkg::COORD_W;
   localparam int OW     = ppg_pkg::OFFS_W;
   localparam int AW     = ppg_pkg::ANGLE_W;
   localparam int TW     = ppg_pkg::TERM_W;
   localparam int QW     = ppg_pkg::ROOT_W;
   localparam int SIDE_W = 2 * CW + OW;
   localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH) + 2;
   localparam int ROM_AW = $clog2(SINE_TABLE_DEPTH) + 1;

   // Configuration registers.
   logic [ppg_pkg::PHASE_W-1:0]  phase_ff;
   logic [ppg_pkg::STRIDE_W-1:0] stride_ff;

   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= ppg_pkg::PHASE_RESET;
         stride_ff <= ppg_pkg::STRIDE_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            ppg_pkg::CSR_PHASE:  phase_ff  <= csr_data[ppg_pkg::PHASE_W-1:0];
            ppg_pkg::CSR_STRIDE: stride_ff <= csr_data[ppg_pkg::STRIDE_W-1:0];
            default: ;
         endcase
      end
   end

   // The pipeline moves whenever the output register can take a result.
   logic pipe_en;
   assign pipe_en    = !rsp_tvalid || rsp_tready;
   assign req_tready = pipe_en && !reset;

   // Input stage: register the request with coordinates saturated.
   logic          vld0_ff;
   logic [CW-1:0] x0_ff;
   logic [CW-1:0] y0_ff;
   logic [CW-1:0] x0_in;
   logic [CW-1:0] y0_in;

   always_comb begin
      x0_in = req_tdata[CW-1:0];
      y0_in = req_tdata[2*CW-1:CW];
      if ({1'b0, x0_in} > (CW+1)'(ppg_pkg::MAX_DIM - 1)) begin
         x0_in = CW'(ppg_pkg::MAX_DIM - 1);
      end
      if ({1'b0, y0_in} > (CW+1)'(ppg_pkg::MAX_DIM - 1)) begin
         y0_in = CW'(ppg_pkg::MAX_DIM - 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff <= 1'b0;
      end else if (pipe_en) begin
         vld0_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         x0_ff <= x0_in;
         y0_ff <= y0_in;
      end
   end

   // Stage 1: squares and the row product.
   logic                      vld1_ff;
   logic [CW-1:0]             x1_ff;
   logic [CW-1:0]             y1_ff;
   logic [2*CW-1:0]           xx1_ff;
   logic [2*CW-1:0]           yy1_ff;
   logic [CW+ppg_pkg::STRIDE_W-1:0] row1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
      end else if (pipe_en) begin
         vld1_ff <= vld0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         x1_ff   <= x0_ff;
         y1_ff   <= y0_ff;
         xx1_ff  <= x0_ff * x0_ff;
         yy1_ff  <= y0_ff * y0_ff;
         row1_ff <= y0_ff * stride_ff;
      end
   end

   // Radicand and byte offset feed the root pipeline.
   logic [ppg_pkg::RAD_W-1:0] rad1;
   logic [OW-1:0]             offs1;
   logic [2*CW:0]             sq_sum1;
   logic [SIDE_W-1:0]         side1;

   always_comb begin
      sq_sum1 = {1'b0, xx1_ff} + {1'b0, yy1_ff};
      rad1    = ppg_pkg::RAD_W'({sq_sum1, 8'b0});
      offs1   = OW'(OW'(row1_ff) + OW'({x1_ff, 2'b00}));
      side1   = {offs1, y1_ff, x1_ff};
   end

   logic              vld2;
   logic [QW-1:0]     root2;
   logic [SIDE_W-1:0] side2;

   ppg_sqrt_pipe #(
      .RAD_W  (ppg_pkg::RAD_W),
      .SIDE_W (SIDE_W)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (vld1_ff),
      .in_rad    (rad1),
      .in_side   (side1),
      .out_valid (vld2),
      .out_root  (root2),
      .out_side  (side2)
   );

   // Stage 3: the four turn-angle products.
   logic          vld3_ff;
   logic [AW-1:0] ax3_ff;
   logic [AW-1:0] ay3_ff;
   logic [AW-1:0] axy3_ff;
   logic [AW-1:0] ar3_ff;
   logic [OW-1:0] offs3_ff;
   logic [CW-1:0] x2;
   logic [CW-1:0] y2;
   logic [CW:0]   xy2;

   always_comb begin
      x2  = side2[CW-1:0];
      y2  = side2[2*CW-1:CW];
      xy2 = {1'b0, x2} + {1'b0, y2};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld3_ff <= 1'b0;
      end else if (pipe_en) begin
         vld3_ff <= vld2;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         ax3_ff   <= AW'(x2 * ppg_pkg::K_X7);
         ay3_ff   <= AW'(y2 * ppg_pkg::K_Y5);
         axy3_ff  <= AW'(xy2 * ppg_pkg::K_XY6);
         ar3_ff   <= AW'(root2 * ppg_pkg::K_R4);
         offs3_ff <= side2[SIDE_W-1:2*CW];
      end
   end

   // Phase offset, table index, quadrant folding and table lookup.
   logic [AW-1:0] tphase;
   logic [AW-1:0] ang3     [4];
   logic [ROM_AW-1:0] addr3 [4];
   logic          neg3     [4];
   logic [2*TW-1:0] rom4   [4];
   logic          neg4_ff  [4];
   logic          vld4_ff;
   logic [OW-1:0] offs4_ff;

   assign tphase  = {phase_ff, 16'b0};
   assign ang3[0] = ax3_ff + tphase;
   assign ang3[1] = ay3_ff - tphase;
   assign ang3[2] = axy3_ff - tphase;
   assign ang3[3] = ar3_ff - tphase;

   for (genvar k = 0; k < 4; k++) begin : g_term
      logic [IDX_W-1:0] idx;
      always_comb begin
         idx     = ang3[k][AW-1 -: IDX_W];
         neg3[k] = idx[IDX_W-1];
         if (idx[IDX_W-2]) begin
            addr3[k] = ROM_AW'(SINE_TABLE_DEPTH) - {1'b0, idx[IDX_W-3:0]};
         end else begin
            addr3[k] = {1'b0, idx[IDX_W-3:0]};
         end
      end

      ppg_sine_rom #(
         .DEPTH (SINE_TABLE_DEPTH)
      ) u_rom (
         .clock (clock),
         .en    (pipe_en),
         .addr  (addr3[k]),
         .data  (rom4[k])
      );

      always_ff @(posedge clock) begin
         if (pipe_en) begin
            neg4_ff[k] <= neg3[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld4_ff <= 1'b0;
      end else if (pipe_en) begin
         vld4_ff <= vld3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         offs4_ff <= offs3_ff;
      end
   end

   // Output stage: pick each term by half wave and average the four.
   logic [TW-1:0]            term4 [4];
   logic [TW+1:0]            sum4;
   logic                     out_vld_ff;
   logic [ppg_pkg::GRAY_W-1:0] gray_ff;
   logic [OW-1:0]            offs_ff;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         term4[k] = neg4_ff[k] ? rom4[k][2*TW-1:TW] : rom4[k][TW-1:0];
      end
      sum4 = (TW+2)'(term4[0]) + (TW+2)'(term4[1])
           + (TW+2)'(term4[2]) + (TW+2)'(term4[3]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (pipe_en) begin
         out_vld_ff <= vld4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         gray_ff <= sum4[TW+1:10];
         offs_ff <= offs4_ff;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {2'b00, offs_ff, gray_ff};

   // The gray level never reaches 255.
   a_gray_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:0] != 8'hFF)
      else $error("gray level out of range");

   // A stalled output freezes the valid bits of stages 3 and 4.
   a_stall_freeze: assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> $stable(vld3_ff) && $stable(vld4_ff))
      else $error("pipeline moved during stall");

   // Reset loads the default row stride.
   a_stride_reset: assert property (@(posedge clock)
      reset |=> stride_ff == ppg_pkg::STRIDE_RESET)
      else $error("row stride not reset");

endmodule
